// File: hw/rtl/moes_pkg.sv
// moes_pkg: shared types and constants for the motion/occupancy event sampler.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package moes_pkg;

  localparam int unsigned SUM_WIDTH_DEF = 25;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned THR_W         = 7;
  localparam int unsigned SMP_W         = 8;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd2;

  localparam logic [CNT_W-1:0] AVG_LIMIT_RST = 16'd5000;
  localparam logic [THR_W-1:0] DEV_THR_RST   = 7'd4;
  localparam logic [CNT_W-1:0] PERIOD_RST    = 16'd300;
  localparam logic [TAG_W-1:0] TAG_RST       = 32'd1;

  localparam logic signed [SMP_W-1:0] FAIL_VAL = 8'sd15;

  localparam int unsigned TRIG_MOTION = 0;
  localparam int unsigned TRIG_OCC    = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_CHECK,
    ST_EMIT
  } moes_state_e;

  typedef struct packed {
    logic load;
    logic update;
    logic div_init;
    logic div_step;
    logic check;
    logic emit;
  } moes_cmd_t;

  typedef struct packed {
    logic accel_valid;
    logic emit_want;
    logic out_free;
  } moes_stat_t;

endpackage

// File: hw/rtl/moes_if.sv
// moes_if: valid/ready channel interfaces for sample beats and record beats.
// Depends on moes_pkg for field widths.
`timescale 1ns / 1ps

interface moes_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       accel_valid;
  logic signed [moes_pkg::SMP_W-1:0]          accel_x;
  logic signed [moes_pkg::SMP_W-1:0]          accel_y;
  logic signed [moes_pkg::SMP_W-1:0]          accel_z;
  logic                                       occupancy;
  logic                                       space_free;

  modport source (output valid, accel_valid, accel_x, accel_y, accel_z, occupancy, space_free,
                  input ready);
  modport sink   (input valid, accel_valid, accel_x, accel_y, accel_z, occupancy, space_free,
                  output ready);
endinterface

interface moes_out_if;
  logic                                       valid;
  logic                                       ready;
  logic [moes_pkg::TAG_W-1:0]                 record_tag;
  logic signed [moes_pkg::SMP_W-1:0]          avg_x;
  logic signed [moes_pkg::SMP_W-1:0]          avg_y;
  logic signed [moes_pkg::SMP_W-1:0]          avg_z;
  logic signed [moes_pkg::SMP_W-1:0]          raw_x;
  logic signed [moes_pkg::SMP_W-1:0]          raw_y;
  logic signed [moes_pkg::SMP_W-1:0]          raw_z;
  logic                                       occupied;
  logic [1:0]                                 trigger_bits;

  modport source (output valid, record_tag, avg_x, avg_y, avg_z, raw_x, raw_y, raw_z,
                  occupied, trigger_bits, input ready);
  modport sink   (input valid, record_tag, avg_x, avg_y, avg_z, raw_x, raw_y, raw_z,
                  occupied, trigger_bits, output ready);
endinterface

// File: hw/rtl/moes_div.sv
// moes_div: restoring divider lane, one quotient bit per step.
// Keeps only the low 8 quotient bits. Depends on moes_pkg.
`timescale 1ns / 1ps

module moes_div #(
  parameter int unsigned SUM_WIDTH = moes_pkg::SUM_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             start_i,
  input  logic                             step_i,
  input  logic [SUM_WIDTH-1:0]             dividend_i,
  input  logic [moes_pkg::CNT_W-1:0]       divisor_i,
  output logic [moes_pkg::SMP_W-1:0]       quot_o
);

  logic [SUM_WIDTH-1:0]           num_q, num_d;
  logic [moes_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [moes_pkg::SMP_W-1:0]     quo_q, quo_d;
  logic [moes_pkg::CNT_W:0]       trial;
  logic [moes_pkg::CNT_W:0]       diff;
  logic                           ge;

  always_comb begin
    trial = {rem_q, num_q[SUM_WIDTH-1]};
    ge    = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      num_d = dividend_i;
      rem_d = '0;
      quo_d = '0;
    end else if (step_i) begin
      num_d = {num_q[SUM_WIDTH-2:0], 1'b0};
      rem_d = ge ? diff[moes_pkg::CNT_W-1:0] : trial[moes_pkg::CNT_W-1:0];
      quo_d = {quo_q[moes_pkg::SMP_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quot_o = quo_q;

endmodule

// File: hw/rtl/moes_ctrl.sv
// moes_ctrl: sequencer for one sample beat: capture, update, divide, check, emit.
// Depends on moes_pkg for the state, command and status types.
`timescale 1ns / 1ps

module moes_ctrl #(
  parameter int unsigned SUM_WIDTH = moes_pkg::SUM_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  moes_pkg::moes_stat_t  stat_i,
  output moes_pkg::moes_cmd_t   cmd_o
);

  localparam int unsigned STEP_W = $clog2(SUM_WIDTH);

  moes_pkg::moes_state_e state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      moes_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = moes_pkg::ST_UPDATE;
      end
      moes_pkg::ST_UPDATE: begin
        state_d = stat_i.accel_valid ? moes_pkg::ST_DIV_INIT : moes_pkg::ST_EMIT;
      end
      moes_pkg::ST_DIV_INIT: begin
        state_d = moes_pkg::ST_DIV_STEP;
      end
      moes_pkg::ST_DIV_STEP: begin
        if (step_q == '0) state_d = moes_pkg::ST_CHECK;
      end
      moes_pkg::ST_CHECK: begin
        state_d = moes_pkg::ST_EMIT;
      end
      moes_pkg::ST_EMIT: begin
        if (!stat_i.emit_want || stat_i.out_free) state_d = moes_pkg::ST_IDLE;
      end
      default: begin
        state_d = moes_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    step_d     = step_q;
    case (state_q)
      moes_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      moes_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      moes_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = STEP_W'(SUM_WIDTH - 1);
      end
      moes_pkg::ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - 1'b1;
      end
      moes_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
      end
      moes_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= moes_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: hw/rtl/moes_dp.sv
// moes_dp: config registers, running sums, trigger/period state, three divider
// lanes and the record output register. Depends on moes_pkg and moes_div.
`timescale 1ns / 1ps

module moes_dp #(
  parameter int unsigned SUM_WIDTH = moes_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [moes_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [moes_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  moes_pkg::moes_cmd_t                   cmd_i,
  output moes_pkg::moes_stat_t                  stat_o,
  input  logic                                  accel_valid_i,
  input  logic signed [moes_pkg::SMP_W-1:0]     accel_x_i,
  input  logic signed [moes_pkg::SMP_W-1:0]     accel_y_i,
  input  logic signed [moes_pkg::SMP_W-1:0]     accel_z_i,
  input  logic                                  occupancy_i,
  input  logic                                  space_free_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [moes_pkg::TAG_W-1:0]            record_tag_o,
  output logic signed [moes_pkg::SMP_W-1:0]     avg_x_o,
  output logic signed [moes_pkg::SMP_W-1:0]     avg_y_o,
  output logic signed [moes_pkg::SMP_W-1:0]     avg_z_o,
  output logic signed [moes_pkg::SMP_W-1:0]     raw_x_o,
  output logic signed [moes_pkg::SMP_W-1:0]     raw_y_o,
  output logic signed [moes_pkg::SMP_W-1:0]     raw_z_o,
  output logic                                  occupied_o,
  output logic [1:0]                            trigger_bits_o
);

  localparam int unsigned CW = moes_pkg::CNT_W;
  localparam int unsigned SW = moes_pkg::SMP_W;

  // config
  logic [CW-1:0]               avg_limit_q, avg_limit_d;
  logic [moes_pkg::THR_W-1:0]  dev_thr_q, dev_thr_d;
  logic [CW-1:0]               period_q, period_d;

  // persistent state
  logic [CW-1:0]               pcount_q, pcount_d;
  logic signed [SUM_WIDTH-1:0] sum_q [3];
  logic signed [SUM_WIDTH-1:0] sum_d [3];
  logic [CW-1:0]               scount_q, scount_d;
  logic                        mfired_q, mfired_d;
  logic                        ofired_q, ofired_d;
  logic                        pend_q, pend_d;
  logic [moes_pkg::TAG_W-1:0]  tag_q, tag_d;
  logic                        ovalid_q, ovalid_d;

  // per-beat payload
  logic signed [SW-1:0]        raw_q [3];
  logic signed [SW-1:0]        raw_d [3];
  logic                        vld_q, vld_d;
  logic                        occ_q, occ_d;
  logic                        space_q, space_d;
  logic [1:0]                  trig_q, trig_d;
  logic                        neg_q [3];
  logic                        neg_d [3];

  // output register
  logic [moes_pkg::TAG_W-1:0]  otag_q, otag_d;
  logic signed [SW-1:0]        oavg_q [3];
  logic signed [SW-1:0]        oavg_d [3];
  logic signed [SW-1:0]        oraw_q [3];
  logic signed [SW-1:0]        oraw_d [3];
  logic                        oocc_q, oocc_d;
  logic [1:0]                  otrig_q, otrig_d;

  // combinational
  logic [SUM_WIDTH:0]          numer [3];
  logic [SUM_WIDTH:0]          numer_abs [3];
  logic [SUM_WIDTH-1:0]        mag [3];
  logic [SW-1:0]               quot [3];
  logic signed [SW-1:0]        avg_n [3];
  logic signed [SW:0]          dev [3];
  logic signed [SW:0]          thr_s;
  logic [2:0]                  over;
  logic [CW-1:0]               pc_inc;
  logic [CW-1:0]               cnt_inc;
  logic                        halve;
  logic                        emit_fire;

  assign stat_o.accel_valid = vld_q;
  assign stat_o.emit_want   = pend_q && space_q;
  assign stat_o.out_free    = !ovalid_q || out_ready_i;
  assign emit_fire          = cmd_i.emit && stat_o.emit_want && stat_o.out_free;

  assign thr_s = $signed({2'b00, dev_thr_q});

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign numer[g]     = {sum_q[g][SUM_WIDTH-1], sum_q[g]}
                        + {{(SUM_WIDTH-CW+2){1'b0}}, scount_q[CW-1:1]};
    assign numer_abs[g] = numer[g][SUM_WIDTH] ? (~numer[g] + 1'b1) : numer[g];
    assign mag[g]       = numer_abs[g][SUM_WIDTH-1:0];
    assign avg_n[g]     = neg_q[g] ? -$signed(quot[g]) : $signed(quot[g]);
    assign dev[g]       = {avg_n[g][SW-1], avg_n[g]} - {raw_q[g][SW-1], raw_q[g]};
    assign over[g]      = (dev[g] > thr_s) || (dev[g] < -thr_s);

    moes_div #(
      .SUM_WIDTH (SUM_WIDTH)
    ) u_div (
      .clk_i      (clk_i),
      .start_i    (cmd_i.div_init),
      .step_i     (cmd_i.div_step),
      .dividend_i (mag[g]),
      .divisor_i  (scount_q),
      .quot_o     (quot[g])
    );
  end

  assign pc_inc = pcount_q + 1'b1;
  assign halve  = scount_q >= avg_limit_q;

  always_comb begin
    avg_limit_d = avg_limit_q;
    dev_thr_d   = dev_thr_q;
    period_d    = period_q;
    pcount_d    = pcount_q;
    scount_d    = scount_q;
    mfired_d    = mfired_q;
    ofired_d    = ofired_q;
    pend_d      = pend_q;
    tag_d       = tag_q;
    ovalid_d    = ovalid_q;
    vld_d       = vld_q;
    occ_d       = occ_q;
    space_d     = space_q;
    trig_d      = trig_q;
    otag_d      = otag_q;
    oocc_d      = oocc_q;
    otrig_d     = otrig_q;
    cnt_inc     = (halve ? {1'b0, scount_q[CW-1:1]} : scount_q) + 1'b1;
    for (int i = 0; i < 3; i++) begin
      sum_d[i]  = sum_q[i];
      raw_d[i]  = raw_q[i];
      neg_d[i]  = neg_q[i];
      oavg_d[i] = oavg_q[i];
      oraw_d[i] = oraw_q[i];
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        moes_pkg::CFG_AVG_LIMIT: avg_limit_d = cfg_data_i;
        moes_pkg::CFG_DEV_THR:   dev_thr_d   = cfg_data_i[moes_pkg::THR_W-1:0];
        moes_pkg::CFG_PERIOD:    period_d    = cfg_data_i;
        default: begin
        end
      endcase
    end

    if (cmd_i.load) begin
      raw_d[0] = accel_x_i;
      raw_d[1] = accel_y_i;
      raw_d[2] = accel_z_i;
      vld_d    = accel_valid_i;
      occ_d    = occupancy_i;
      space_d  = space_free_i;
    end

    if (cmd_i.update) begin
      trig_d   = '0;
      pcount_d = pc_inc;
      if (pc_inc >= period_q) begin
        pcount_d = '0;
        pend_d   = 1'b1;
        mfired_d = 1'b0;
        ofired_d = 1'b0;
      end
      if (occ_q && !ofired_d) begin
        pend_d   = 1'b1;
        ofired_d = 1'b1;
        pcount_d = CW'(1);
        trig_d[moes_pkg::TRIG_OCC] = 1'b1;
      end
      if (vld_q) begin
        for (int i = 0; i < 3; i++) begin
          sum_d[i] = (halve ? (sum_q[i] >>> 1) : sum_q[i])
                   + $signed({{(SUM_WIDTH-SW){raw_q[i][SW-1]}}, raw_q[i]});
        end
        scount_d = (cnt_inc == '0) ? CW'(1) : cnt_inc;
      end
    end

    if (cmd_i.div_init) begin
      for (int i = 0; i < 3; i++) begin
        neg_d[i] = numer[i][SUM_WIDTH];
      end
    end

    if (cmd_i.check) begin
      if ((over != '0) && !mfired_q) begin
        pend_d   = 1'b1;
        mfired_d = 1'b1;
        pcount_d = CW'(1);
        trig_d[moes_pkg::TRIG_MOTION] = 1'b1;
      end
    end

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    if (emit_fire) begin
      ovalid_d = 1'b1;
      otag_d   = tag_q;
      tag_d    = tag_q + 1'b1;
      pend_d   = 1'b0;
      oocc_d   = occ_q;
      otrig_d  = trig_q;
      for (int i = 0; i < 3; i++) begin
        oavg_d[i] = vld_q ? avg_n[i] : moes_pkg::FAIL_VAL;
        oraw_d[i] = vld_q ? raw_q[i] : moes_pkg::FAIL_VAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_limit_q <= moes_pkg::AVG_LIMIT_RST;
      dev_thr_q   <= moes_pkg::DEV_THR_RST;
      period_q    <= moes_pkg::PERIOD_RST;
      pcount_q    <= '0;
      scount_q    <= '0;
      mfired_q    <= 1'b0;
      ofired_q    <= 1'b0;
      pend_q      <= 1'b0;
      tag_q       <= moes_pkg::TAG_RST;
      ovalid_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      avg_limit_q <= avg_limit_d;
      dev_thr_q   <= dev_thr_d;
      period_q    <= period_d;
      pcount_q    <= pcount_d;
      scount_q    <= scount_d;
      mfired_q    <= mfired_d;
      ofired_q    <= ofired_d;
      pend_q      <= pend_d;
      tag_q       <= tag_d;
      ovalid_q    <= ovalid_d;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vld_q   <= vld_d;
    occ_q   <= occ_d;
    space_q <= space_d;
    trig_q  <= trig_d;
    otag_q  <= otag_d;
    oocc_q  <= oocc_d;
    otrig_q <= otrig_d;
    for (int i = 0; i < 3; i++) begin
      raw_q[i]  <= raw_d[i];
      neg_q[i]  <= neg_d[i];
      oavg_q[i] <= oavg_d[i];
      oraw_q[i] <= oraw_d[i];
    end
  end

  assign out_valid_o    = ovalid_q;
  assign record_tag_o   = otag_q;
  assign avg_x_o        = oavg_q[0];
  assign avg_y_o        = oavg_q[1];
  assign avg_z_o        = oavg_q[2];
  assign raw_x_o        = oraw_q[0];
  assign raw_y_o        = oraw_q[1];
  assign raw_z_o        = oraw_q[2];
  assign occupied_o     = oocc_q;
  assign trigger_bits_o = otrig_q;

endmodule

// File: hw/rtl/motion_occupancy_event_sampler_unit.sv
// motion_occupancy_event_sampler_unit: top level of the event sampler.
// Depends on moes_pkg, moes_if, moes_ctrl, moes_dp and moes_div.
//
// Usage:
//   sample_i carries one tick per beat: read-valid flag, x/y/z sample,
//   occupancy level and buffer-space flag. record_o carries zero or one
//   record per tick: tag, averages, raw values, occupancy and trigger bits.
//   Config registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Sequence:
//   A tick with a valid read passes through idle/capture, update, divider load,
//   SUM_WIDTH restoring steps in three parallel lanes, check and emit, where
//   its record is loaded into the output register. A failed read skips the
//   divider and the check. sample_i.ready is high only between ticks.
// Reset:
//   Sums, counts, triggers and pending record clear, tag restarts at 1 and
//   the config registers take their default values.
// Stall:
//   A finished record sits in the output register; the next tick is taken
//   meanwhile and only waits at emit if it also has a record to deliver.
`timescale 1ns / 1ps

module motion_occupancy_event_sampler_unit #(
  parameter int unsigned SUM_WIDTH = moes_pkg::SUM_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [moes_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [moes_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  moes_in_if.sink                           sample_i,
  moes_out_if.source                        record_o
);

  moes_pkg::moes_cmd_t  cmd;
  moes_pkg::moes_stat_t stat;

  moes_ctrl #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  moes_dp #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .accel_valid_i  (sample_i.accel_valid),
    .accel_x_i      (sample_i.accel_x),
    .accel_y_i      (sample_i.accel_y),
    .accel_z_i      (sample_i.accel_z),
    .occupancy_i    (sample_i.occupancy),
    .space_free_i   (sample_i.space_free),
    .out_valid_o    (record_o.valid),
    .out_ready_i    (record_o.ready),
    .record_tag_o   (record_o.record_tag),
    .avg_x_o        (record_o.avg_x),
    .avg_y_o        (record_o.avg_y),
    .avg_z_o        (record_o.avg_z),
    .raw_x_o        (record_o.raw_x),
    .raw_y_o        (record_o.raw_y),
    .raw_z_o        (record_o.raw_z),
    .occupied_o     (record_o.occupied),
    .trigger_bits_o (record_o.trigger_bits)
  );

`ifndef ASSERT_OFF
  a_one_tick_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("sample beat taken while previous tick still in work");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && stat.emit_want && stat.out_free) |=> record_o.valid)
    else $error("emitted record did not reach the output register");

  a_record_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(record_o.valid) |-> $past(cmd.emit && stat.emit_want))
    else $error("record beat appeared without a pending record");
`endif

endmodule
